@@ src/lnds_pkg.sv @@
// Package for the LIF neuron with delta synapses: widths, configuration
// record, register indexes and the saturation helper.
// No dependencies; used by every other file of the block but lnds_if.
package lnds_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int MAX_REFRACTORY = 1023;
    localparam int REF_W          = $clog2(MAX_REFRACTORY + 1);
    localparam int PROD_W         = VALUE_WIDTH + 18;

    localparam logic signed [63:0] V_MAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] V_MIN = -V_MAX - 64'sd1;

    typedef enum logic [2:0] {
        REG_DECAY     = 3'd0,
        REG_GAIN      = 3'd1,
        REG_BIAS      = 3'd2,
        REG_THRESHOLD = 3'd3,
        REG_RESET     = 3'd4,
        REG_FLOOR     = 3'd5,
        REG_REF_STEPS = 3'd6,
        REG_KEEP      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        [16:0] decay;
        logic        [31:0] gain;
        logic signed [31:0] bias;
        logic signed [31:0] thr;
        logic signed [31:0] rst;
        logic signed [31:0] flr;
        logic        [9:0]  steps;
        logic               keep;
    } t_cfg;

    function automatic logic signed [VALUE_WIDTH-1:0] sat_val(input logic signed [63:0] x);
        logic signed [63:0] y;
        if (x > V_MAX) begin
            y = V_MAX;
        end else if (x < V_MIN) begin
            y = V_MIN;
        end else begin
            y = x;
        end
        return y[VALUE_WIDTH-1:0];
    endfunction

endpackage

@@ src/lnds_if.sv @@
// Stream interfaces of the neuron: input tick words and result words.
// Depends on nothing; payload widths are fixed by the field list.
interface lnds_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] spike_weight;
    logic signed [31:0] next_current;

    modport source (output valid, output spike_weight, output next_current, input ready);
    modport sink   (input valid, input spike_weight, input next_current, output ready);
endinterface

interface lnds_out_if;
    logic               valid;
    logic               ready;
    logic               spike_out;
    logic signed [31:0] membrane_level;

    modport source (output valid, output spike_out, output membrane_level, input ready);
    modport sink   (input valid, input spike_out, input membrane_level, output ready);
endinterface

@@ src/lnds_cfg.sv @@
// Configuration register file of the neuron, written through a plain port.
// Depends on lnds_pkg for the register indexes and the configuration record.
module lnds_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output lnds_pkg::t_cfg      o_cfg
);

    lnds_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay <= 17'd64884;
            r_cfg.gain  <= 32'd6678;
            r_cfg.bias  <= 32'sd0;
            r_cfg.thr   <= 32'sd983040;
            r_cfg.rst   <= 32'sd0;
            r_cfg.flr   <= 32'sh8000_0000;
            r_cfg.steps <= 10'd20;
            r_cfg.keep  <= 1'b0;
        end else if (i_cfg_we) begin
            case (lnds_pkg::t_cfg_idx'(i_cfg_idx))
                lnds_pkg::REG_DECAY:     r_cfg.decay <= i_cfg_data[16:0];
                lnds_pkg::REG_GAIN:      r_cfg.gain  <= i_cfg_data;
                lnds_pkg::REG_BIAS:      r_cfg.bias  <= $signed(i_cfg_data);
                lnds_pkg::REG_THRESHOLD: r_cfg.thr   <= $signed(i_cfg_data);
                lnds_pkg::REG_RESET:     r_cfg.rst   <= $signed(i_cfg_data);
                lnds_pkg::REG_FLOOR:     r_cfg.flr   <= $signed(i_cfg_data);
                lnds_pkg::REG_REF_STEPS: r_cfg.steps <= i_cfg_data[9:0];
                lnds_pkg::REG_KEEP:      r_cfg.keep  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/lnds_core.sv @@
// Neuron state and one-tick update: decay, current integration, refractory
// gathering, floor clamp and threshold. Depends on lnds_pkg.
module lnds_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  lnds_pkg::t_cfg      i_cfg,
    input  logic signed [31:0]  i_spike_weight,
    input  logic signed [31:0]  i_next_current,
    output logic                o_spike,
    output logic signed [31:0]  o_level
);

    localparam int VW = lnds_pkg::VALUE_WIDTH;
    localparam int RW = lnds_pkg::REF_W;
    localparam int PW = lnds_pkg::PROD_W;

    logic signed [VW-1:0] r_pot, n_pot;
    logic signed [31:0]   r_held;
    logic [RW-1:0]        r_left, n_left;
    logic signed [VW-1:0] r_acc, n_acc;

    logic [16:0]          w_dcl;
    logic signed [32:0]   w_cur_sum;
    logic signed [31:0]   w_cur;
    logic signed [63:0]   w_gprod;
    logic signed [63:0]   w_gterm;
    logic signed [63:0]   w_w64;
    logic signed [VW-1:0] w_acc_w;
    logic signed [VW-1:0] w_dec_in;
    logic signed [PW-1:0] w_dprod;
    logic signed [PW-1:0] w_dround;
    logic signed [VW-1:0] w_floor;
    logic signed [VW-1:0] w_reset;
    logic signed [VW-1:0] w_v;
    logic [31:0]          w_steps;
    logic [RW-1:0]        w_load;

    always_comb begin
        w_dcl     = (i_cfg.decay > 17'd65536) ? 17'd65536 : i_cfg.decay;
        w_cur_sum = 33'(r_held) + 33'(i_cfg.bias);
        if (w_cur_sum > 33'sd2147483647) begin
            w_cur = 32'sh7fff_ffff;
        end else if (w_cur_sum < $signed(33'h1_8000_0000)) begin
            w_cur = 32'sh8000_0000;
        end else begin
            w_cur = w_cur_sum[31:0];
        end
        w_gprod  = 64'(w_cur) * 64'($signed({1'b0, i_cfg.gain}));
        w_gterm  = (w_gprod + 64'sd8388608) >>> 24;
        w_w64    = 64'(i_spike_weight);
        w_acc_w  = lnds_pkg::sat_val(64'(r_acc) + w_w64);
        w_dec_in = (r_left == '0) ? r_pot : w_acc_w;
        w_dprod  = PW'(w_dec_in) * PW'($signed({1'b0, w_dcl}));
        w_dround = (w_dprod + PW'(32768)) >>> 16;
        w_floor  = lnds_pkg::sat_val(64'(i_cfg.flr));
        w_reset  = lnds_pkg::sat_val(64'(i_cfg.rst));
        w_steps  = 32'(i_cfg.steps);
        w_load   = RW'((w_steps > 32'(lnds_pkg::MAX_REFRACTORY))
                       ? 32'(lnds_pkg::MAX_REFRACTORY) : w_steps);

        w_v    = lnds_pkg::sat_val(w_gterm + 64'(w_dround) + w_w64);
        n_pot  = r_pot;
        n_acc  = r_acc;
        n_left = r_left;
        if (r_left == '0) begin
            if (i_cfg.keep && (r_acc != '0)) begin
                w_v   = lnds_pkg::sat_val(64'(w_v) + 64'(r_acc));
                n_acc = '0;
            end
            n_pot = (w_v < w_floor) ? w_floor : w_v;
        end else begin
            if (i_cfg.keep) begin
                n_acc = lnds_pkg::sat_val(64'(w_dround));
            end
            n_left = r_left - RW'(1);
        end

        o_spike = (64'(n_pot) >= 64'(i_cfg.thr));
        if (o_spike) begin
            n_left = w_load;
            n_pot  = w_reset;
        end
        o_level = 32'(64'(n_pot));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pot  <= '0;
            r_held <= '0;
            r_left <= '0;
            r_acc  <= '0;
        end else if (i_step) begin
            r_pot  <= n_pot;
            r_held <= i_next_current;
            r_left <= n_left;
            r_acc  <= n_acc;
        end
    end

    a_ref_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_left != '0) && !o_spike) |=> (r_left == $past(r_left) - RW'(1)))
        else $error("refractory counter did not count down");

    a_spike_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_spike) |=> (r_pot == $past(w_reset) && r_left == $past(w_load)))
        else $error("spike did not load reset level and refractory count");

    a_floor_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_left == '0) && !o_spike) |=> (r_pot >= $past(w_floor)))
        else $error("potential fell below floor");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_pot) && $stable(r_left) && $stable(r_acc)))
        else $error("neuron state moved without a tick");

endmodule

@@ src/lif_neuron_delta_synapse_top.sv @@
// Top level of the LIF neuron with delta synapses: input register, core,
// result register. Depends on lnds_pkg, lnds_if, lnds_cfg and lnds_core.
//
//  channel  dir  payload                              handshake
//  i_in     in   spike_weight[31:0], next_current     valid/ready
//  o_out    out  spike_out, membrane_level[31:0]      valid/ready
//  i_cfg_*  in   idx[2:0], data[31:0]                 write enable
//
// One tick a cycle unless the result stalls; a word passes both registers.
// The state update (gain and decay multiplies, sum, clamp, threshold) is
// combinational from the input register to the result and state registers.
// Synchronous active-low reset clears state and loads register defaults.
// A stalled result holds; one more input word waits in the input register.
module lif_neuron_delta_synapse_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lnds_in_if.sink       i_in,
    lnds_out_if.source    o_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    lnds_pkg::t_cfg     w_cfg;
    logic               r_in_valid;
    logic signed [31:0] r_in_w;
    logic signed [31:0] r_in_nxt;
    logic               r_out_valid;
    logic               r_out_spike;
    logic signed [31:0] r_out_level;
    logic               w_advance;
    logic               w_step;
    logic               w_spike;
    logic signed [31:0] w_level;

    lnds_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    lnds_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_cfg          (w_cfg),
        .i_spike_weight (r_in_w),
        .i_next_current (r_in_nxt),
        .o_spike        (w_spike),
        .o_level        (w_level)
    );

    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_w   <= i_in.spike_weight;
            r_in_nxt <= i_in.next_current;
        end
        if (w_step) begin
            r_out_spike <= w_spike;
            r_out_level <= w_level;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.spike_out      = r_out_spike;
    assign o_out.membrane_level = r_out_level;

endmodule

@@ test/lnds_tick_checker.sv @@
// Scoreboard for the LIF neuron: watches the tick and result channels and the
// register write port, predicts every result word and compares it.
// Depends on lnds_pkg and lnds_if.
module lnds_tick_checker
    import lnds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lnds_in_if          in_mon,
    lnds_out_if         out_mon,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -WORD_HI - 64'sd1;

    typedef struct packed {
        logic               spike;
        logic signed [31:0] level;
    } t_tick_res;

    t_tick_res          tick_q[$];
    t_tick_res          want_r;
    t_tick_res          made_r;
    t_cfg               cfg;
    logic signed [31:0] mem_v;
    logic signed [31:0] held_i;
    logic signed [31:0] refr_acc;
    logic [REF_W-1:0]   refr_left;
    int                 errors = 0;

    function automatic longint clip_word(longint x);
        if (x > WORD_HI) return WORD_HI;
        if (x < WORD_LO) return WORD_LO;
        return x;
    endfunction

    function automatic longint decay_of(longint v);
        longint d;
        d = (cfg.decay > 17'd65536) ? 64'sd65536 : longint'(cfg.decay);
        return (v * d + 64'sd32768) >>> 16;
    endfunction

    task automatic advance_neuron(input logic signed [31:0] w,
                                  input logic signed [31:0] nxt,
                                  output t_tick_res r);
        longint cur;
        longint gt;
        longint v;
        longint fl;
        logic   fire;
        fire = 1'b0;
        if (refr_left == '0) begin
            cur = clip_word(longint'(held_i) + longint'($signed(cfg.bias)));
            gt  = (cur * longint'(cfg.gain) + 64'sd8388608) >>> 24;
            v   = clip_word(gt + decay_of(longint'(mem_v)) + longint'(w));
            fl  = longint'($signed(cfg.flr));
            if (cfg.keep && refr_acc != 0) begin
                v        = clip_word(v + longint'(refr_acc));
                refr_acc = '0;
            end
            mem_v = 32'((v < fl) ? fl : v);
        end else begin
            if (cfg.keep)
                refr_acc = 32'(clip_word(decay_of(clip_word(longint'(refr_acc)
                                                            + longint'(w)))));
            refr_left = refr_left - REF_W'(1);
        end
        if (mem_v >= $signed(cfg.thr)) begin
            refr_left = (32'(cfg.steps) > MAX_REFRACTORY) ? REF_W'(MAX_REFRACTORY)
                                                          : REF_W'(cfg.steps);
            mem_v     = $signed(cfg.rst);
            fire      = 1'b1;
        end
        held_i  = nxt;
        r.spike = fire;
        r.level = mem_v;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.decay = 17'd64884;
            cfg.gain  = 32'd6678;
            cfg.bias  = '0;
            cfg.thr   = 32'sd983040;
            cfg.rst   = '0;
            cfg.flr   = 32'h8000_0000;
            cfg.steps = 10'd20;
            cfg.keep  = 1'b0;
            mem_v     = '0;
            held_i    = '0;
            refr_acc  = '0;
            refr_left = '0;
            tick_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    REG_DECAY:     cfg.decay = i_cfg_data[16:0];
                    REG_GAIN:      cfg.gain  = i_cfg_data;
                    REG_BIAS:      cfg.bias  = i_cfg_data;
                    REG_THRESHOLD: cfg.thr   = i_cfg_data;
                    REG_RESET:     cfg.rst   = i_cfg_data;
                    REG_FLOOR:     cfg.flr   = i_cfg_data;
                    REG_REF_STEPS: cfg.steps = i_cfg_data[9:0];
                    REG_KEEP:      cfg.keep  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready) begin
                if (tick_q.size() == 0) begin
                    $error("result word with none expected: spike_out %0d membrane_level %0d",
                           out_mon.spike_out, out_mon.membrane_level);
                    errors++;
                end else begin
                    want_r = tick_q.pop_front();
                    if (out_mon.spike_out !== want_r.spike) begin
                        $error("spike_out mismatch: expected %0d, actual %0d",
                               want_r.spike, out_mon.spike_out);
                        errors++;
                    end
                    if (out_mon.membrane_level !== want_r.level) begin
                        $error("membrane_level mismatch: expected %0d, actual %0d",
                               want_r.level, out_mon.membrane_level);
                        errors++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                advance_neuron(in_mon.spike_weight, in_mon.next_current, made_r);
                tick_q.push_back(made_r);
            end
        end
        o_pending <= tick_q.size();
        o_errors  <= errors;
    end

endmodule

@@ test/tb_lif_neuron_delta_synapse_top.sv @@
// Testbench top for the LIF neuron: clock, reset, register writes, tick words
// in bursts and a stalling result sink; the verdict comes from lnds_tick_checker.
// Depends on lnds_pkg, lnds_if, lif_neuron_delta_synapse_top and the checker.
module tb_lif_neuron_delta_synapse_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lnds_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    int          chk_errors;
    int          chk_pending;
    int          cycle_cnt = 0;
    int          burst_left = 1;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          rx_mode;
    int          rx_seg;
    int          rx_tick = 0;
    t_cfg        phase_cfg;

    lnds_in_if  in_ch();
    lnds_out_if out_ch();

    lif_neuron_delta_synapse_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    lnds_tick_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_lif_neuron_delta_synapse_top: FAIL");
            $finish;
        end
    end

    // result sink: random stall patterns, plus a long hold on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            rx_mode = $urandom_range(0, 3);
            rx_seg  = $urandom_range(4, 60);
            repeat (rx_seg) begin
                @(posedge i_clk);
                if (hold_asked != hold_served) begin
                    hold_served = hold_asked;
                    out_ch.ready <= 1'b0;
                    for (int k = 0; k < LONG_HOLD; k++) @(posedge i_clk);
                end
                rx_tick++;
                case (rx_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (rx_tick % 3 == 0);
                endcase
            end
        end
    end

    function automatic t_cfg make_cfg(logic [16:0] decay, logic [31:0] gain,
                                      logic [31:0] bias, logic [31:0] thr,
                                      logic [31:0] rst, logic [31:0] flr,
                                      logic [9:0] steps, logic keep);
        t_cfg c;
        c.decay = decay;
        c.gain  = gain;
        c.bias  = bias;
        c.thr   = thr;
        c.rst   = rst;
        c.flr   = flr;
        c.steps = steps;
        c.keep  = keep;
        return c;
    endfunction

    function automatic t_cfg random_cfg(int ph);
        t_cfg c;
        if (ph == 3) begin
            c.decay = 17'($urandom_range(0, 131071));
            c.gain  = $urandom;
            c.bias  = $urandom;
            c.thr   = $urandom;
            c.rst   = $urandom;
            c.flr   = $urandom;
            c.steps = 10'($urandom_range(0, 1023));
            c.keep  = 1'($urandom_range(0, 1));
            return c;
        end
        c.decay = (ph % 4 == 1) ? 17'($urandom_range(65537, 131071))
                                : 17'($urandom_range(55000, 65536));
        c.gain  = $urandom_range(0, 1 << 20);
        c.bias  = int'($urandom_range(0, 6553600)) - 3276800;
        c.thr   = int'($urandom_range(131072, 1966080));
        if ($urandom_range(0, 7) == 0)
            c.rst = c.thr + int'($urandom_range(0, 65536));
        else
            c.rst = int'($urandom_range(0, 655360)) - 655360;
        c.flr   = $urandom_range(0, 1) ? -32'sd1310720 : 32'h8000_0000;
        c.steps = (ph == 6) ? 10'd1023 : 10'($urandom_range(0, 25));
        c.keep  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic logic [31:0] rand_weight();
        if ($urandom_range(0, 15) == 0) return $urandom;
        return int'($urandom_range(0, 786432)) - 262144;
    endfunction

    function automatic logic [31:0] rand_current();
        if ($urandom_range(0, 15) == 0) return $urandom;
        return int'($urandom_range(0, 26214400)) - 13107200;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(t_cfg c);
        write_reg(REG_DECAY,     32'(c.decay));
        write_reg(REG_GAIN,      c.gain);
        write_reg(REG_BIAS,      c.bias);
        write_reg(REG_THRESHOLD, c.thr);
        write_reg(REG_RESET,     c.rst);
        write_reg(REG_FLOOR,     c.flr);
        write_reg(REG_REF_STEPS, 32'(c.steps));
        write_reg(REG_KEEP,      32'(c.keep));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(logic [31:0] w, logic [31:0] cur);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.spike_weight <= w;
        in_ch.next_current <= cur;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
    endtask

    // drop valid and hold until every expected result word is out
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.spike_weight <= '0;
        in_ch.next_current <= '0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= REG_DECAY;
        i_cfg_data         <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // saturating extremes, decay above one
        apply_config(make_cfg(17'd131071, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h8000_0000, 10'd0, 1'b0));
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF);
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // reset above threshold, longest refractory load
        apply_config(make_cfg(17'd0, 32'd0, 32'h8000_0000, 32'h8000_0000,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd1023, 1'b1));
        send_word(32'h7FFF_FFFF, 32'h0000_0000);
        send_word(32'h8000_0000, 32'h0000_0000);
        send_word(32'h0000_0001, 32'h0000_0001);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // spike, gather during refractory, floor clamp
        apply_config(make_cfg(17'd65536, 32'd16777216, 32'd0, 32'd655360,
                              32'd0, -32'sd327680, 10'd3, 1'b1));
        send_word(32'd1310720, 32'd0);
        send_word(32'd65536, 32'd0);
        send_word(32'd131072, 32'd0);
        send_word(-32'sd65536, 32'd131072);
        send_word(32'd0, 32'd0);
        send_word(-32'sd6553600, 32'd0);
        send_word(32'd0, 32'd0);
        drain();

        // gathered input kept while the mode is off, added once it is back on
        phase_cfg = make_cfg(17'd32768, 32'd6678, 32'd0, 32'd655360,
                             32'd0, 32'h8000_0000, 10'd4, 1'b1);
        apply_config(phase_cfg);
        send_word(32'd1310720, 32'd0);
        send_word(32'd196608, 32'd0);
        send_word(32'd196608, 32'd0);
        drain();
        phase_cfg.keep = 1'b0;
        apply_config(phase_cfg);
        send_word(32'd65536, 32'd0);
        send_word(32'd65536, 32'd0);
        send_word(32'd0, 32'd0);
        drain();
        phase_cfg.keep = 1'b1;
        apply_config(phase_cfg);
        send_word(32'd0, 32'd0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            apply_config(random_cfg(ph));
            for (int n = 0; n < 150; n++) begin
                if (ph == 2 && n == 40)
                    hold_asked++;
                if (ph == 5 && n == 75)
                    drain();
                send_word(rand_weight(), rand_current());
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (chk_errors == 0 && chk_pending == 0)
            $display("tb_lif_neuron_delta_synapse_top: PASS");
        else
            $display("tb_lif_neuron_delta_synapse_top: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
src/lnds_pkg.sv
src/lnds_if.sv
src/lnds_cfg.sv
src/lnds_core.sv
src/lif_neuron_delta_synapse_top.sv
test/lnds_tick_checker.sv
test/tb_lif_neuron_delta_synapse_top.sv
